>>> hw/rtl/cra_pkg.sv
`default_nettype none

package cra_pkg;

   localparam int ADDR_W          = 20;
   localparam int HANDLE_W        = 6;
   localparam int STATUS_W        = 3;
   localparam int ROW_W           = 13;
   localparam int COORD_W         = 16;
   localparam int NUM_HANDLES_DEF = 32;
   localparam int WORD_BITS       = 32;
   localparam int WORD_SHIFT      = $clog2(WORD_BITS);
   // Row words and height of a rectangle, and the word count they give
   localparam int ROWS_W          = 13;
   localparam int HEIGHT_W        = COORD_W + 1;
   localparam int NWORDS_W        = (ROWS_W - 1) + COORD_W;

   localparam logic [ADDR_W-1:0] AREA_START_RST = ADDR_W'((90 * 1024) / 4);
   localparam logic [ADDR_W-1:0] AREA_END_RST   = ADDR_W'((156 * 1024 - 1024) / 4);

   // Configuration register indexes
   localparam logic REG_AREA_START = 1'b0;
   localparam logic REG_AREA_END   = 1'b1;

   // Command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Result kinds
   localparam logic KIND_MOVE  = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_HANDLE  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_SIZE   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd4;

   // Result selection from the controller
   localparam int EM_W = 3;
   localparam logic [EM_W-1:0] EM_FREE      = 3'd0;
   localparam logic [EM_W-1:0] EM_NO_HANDLE = 3'd1;
   localparam logic [EM_W-1:0] EM_BAD_SIZE  = 3'd2;
   localparam logic [EM_W-1:0] EM_NO_SPACE  = 3'd3;
   localparam logic [EM_W-1:0] EM_ALLOC     = 3'd4;
   localparam logic [EM_W-1:0] EM_MOVE      = 3'd5;

   typedef struct packed {
      logic            load;
      logic            hnext;
      logic            comp_init;
      logic            scan_init;
      logic            scan_rd;
      logic            pick_apply;
      logic            comp_end;
      logic            emit;
      logic [EM_W-1:0] emit_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic hfree;
      logic hlast;
      logic bad_size;
      logic fits;
      logic scan_last;
      logic pick_found;
      logic pick_moves;
   } dp_stat_type;

endpackage

`default_nettype wire

>>> hw/rtl/cra_ram.sv
`default_nettype none

module cra_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 32
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/cra_ctrl.sv
`default_nettype none

module cra_ctrl import cra_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        req_cmd,
   output      logic        busy,
   input  wire dp_stat_type stat,
   output      dp_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FREE   = 4'd1;
   localparam logic [3:0] S_FIND   = 4'd2;
   localparam logic [3:0] S_SIZE   = 4'd3;
   localparam logic [3:0] S_CHECK  = 4'd4;
   localparam logic [3:0] S_ALLOC  = 4'd5;
   localparam logic [3:0] S_CSTART = 4'd6;
   localparam logic [3:0] S_SCAN   = 4'd7;
   localparam logic [3:0] S_SDRAIN = 4'd8;
   localparam logic [3:0] S_PICK   = 4'd9;
   localparam logic [3:0] S_SETTLE = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       compacted_ff, compacted_in;

   always_comb begin
      state_in     = state_ff;
      compacted_in = compacted_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load     = 1'b1;
               compacted_in = 1'b0;
               state_in     = (req_cmd == CMD_FREE) ? S_FREE : S_FIND;
            end
         end
         S_FREE: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_FREE;
            state_in     = S_IDLE;
         end
         S_FIND: begin
            if (stat.hfree) begin
               state_in = S_SIZE;
            end else if (stat.hlast) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EM_NO_HANDLE;
               state_in     = S_IDLE;
            end else begin
               cmd.hnext = 1'b1;
            end
         end
         S_SIZE: begin
            // wait for the word count product
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.bad_size) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EM_BAD_SIZE;
               state_in     = S_IDLE;
            end else if (stat.fits) begin
               state_in = S_ALLOC;
            end else if (compacted_ff) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EM_NO_SPACE;
               state_in     = S_IDLE;
            end else begin
               compacted_in = 1'b1;
               state_in     = S_CSTART;
            end
         end
         S_ALLOC: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_ALLOC;
            state_in     = S_IDLE;
         end
         S_CSTART: begin
            cmd.comp_init = 1'b1;
            cmd.scan_init = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (stat.scan_last) begin
               state_in = S_SDRAIN;
            end
         end
         S_SDRAIN: begin
            // last table read still in flight
            state_in = S_PICK;
         end
         S_PICK: begin
            if (stat.pick_found) begin
               cmd.pick_apply = 1'b1;
               cmd.scan_init  = 1'b1;
               cmd.emit       = stat.pick_moves;
               cmd.emit_sel   = EM_MOVE;
               state_in       = S_SCAN;
            end else begin
               cmd.comp_end = 1'b1;
               state_in     = S_SETTLE;
            end
         end
         S_SETTLE: begin
            // let the free space register follow the new bump pointer
            state_in = S_CHECK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         compacted_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         compacted_ff <= compacted_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/cra_dp.sv
`default_nettype none

module cra_dp import cra_pkg::*; #(
   parameter int NUM_HANDLES = NUM_HANDLES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic signed [COORD_W-1:0]  req_origin_x,
   input  wire logic signed [COORD_W-1:0]  req_origin_y,
   input  wire logic signed [COORD_W-1:0]  req_corner_x,
   input  wire logic signed [COORD_W-1:0]  req_corner_y,
   input  wire logic [HANDLE_W-1:0]        req_free_handle,
   input  wire logic                       csr_valid,
   input  wire logic                       csr_index,
   input  wire logic [ADDR_W-1:0]          csr_data,
   input  wire dp_cmd_type                 cmd,
   output      dp_stat_type                stat,
   output      logic                       rsp_valid,
   output      logic                       rsp_kind,
   output      logic [STATUS_W-1:0]        rsp_status,
   output      logic [HANDLE_W-1:0]        rsp_handle,
   output      logic [ADDR_W-1:0]          rsp_base_addr,
   output      logic [ADDR_W-1:0]          rsp_src_addr,
   output      logic [ADDR_W-1:0]          rsp_word_count,
   output      logic [ROW_W-1:0]           rsp_row_words,
   output      logic                       rsp_last
);

   localparam int IDX_W = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_HANDLES - 1);
   localparam logic signed [HEIGHT_W-1:0] ROUND_UP = HEIGHT_W'(WORD_BITS - 1);
   localparam int ENTRY_W = 2 * ADDR_W;

   // Area configuration and bump pointer
   logic [ADDR_W-1:0] area_start_ff, area_end_ff;
   logic [ADDR_W-1:0] next_free_ff;
   logic [ADDR_W-1:0] space_left_ff, space_left_in;

   // Captured transaction
   logic signed [COORD_W-1:0] ox_ff, oy_ff, cx_ff, cy_ff;
   logic [HANDLE_W-1:0]       fh_ff;
   logic                      fh_ok;
   logic [IDX_W-1:0]          fh_idx;

   // Sizing
   logic signed [HEIGHT_W-1:0] ox_ext, cx_ext, oy_ext, cy_ext;
   logic signed [HEIGHT_W-1:0] lq, rq, rows_full;
   logic signed [ROWS_W-1:0]   rows_ff, rows_in;
   logic signed [HEIGHT_W-1:0] height_ff, height_in;
   logic [NWORDS_W-1:0]        nwords_ff, nwords_in;

   // Handle table
   logic [NUM_HANDLES-1:0] valid_ff;
   logic [NUM_HANDLES-1:0] done_ff;
   logic [IDX_W-1:0]       hidx_ff;

   // Compaction walk
   logic [IDX_W-1:0]   scan_idx_ff, rd_idx_ff, pick_idx_ff;
   logic               rd_v_ff, pick_found_ff;
   logic [ADDR_W-1:0]  w_ff, low_ff, pick_base_ff, pick_size_ff;
   logic [ADDR_W-1:0]  rd_base, rd_size;
   logic               cand;

   // Table memory port
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [ADDR_W-1:0]   rsp_base_ff, rsp_base_in;
   logic [ADDR_W-1:0]   rsp_src_ff, rsp_src_in;
   logic [ADDR_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [ROW_W-1:0]    rsp_rows_ff, rsp_rows_in;

   logic do_alloc;

   always_ff @(posedge clock) begin
      if (reset) begin
         area_start_ff <= AREA_START_RST;
         area_end_ff   <= AREA_END_RST;
      end else if (csr_valid) begin
         if (csr_index == REG_AREA_START) begin
            area_start_ff <= csr_data;
         end
         if (csr_index == REG_AREA_END) begin
            area_end_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ox_ff <= req_origin_x;
         oy_ff <= req_origin_y;
         cx_ff <= req_corner_x;
         cy_ff <= req_corner_y;
         fh_ff <= req_free_handle;
      end
   end

   assign fh_ok  = ({1'b0, fh_ff} < (HANDLE_W + 1)'(NUM_HANDLES));
   assign fh_idx = fh_ff[IDX_W-1:0];

   // Align the left edge down and the right edge up to whole words
   always_comb begin
      ox_ext    = {ox_ff[COORD_W-1], ox_ff};
      cx_ext    = {cx_ff[COORD_W-1], cx_ff};
      oy_ext    = {oy_ff[COORD_W-1], oy_ff};
      cy_ext    = {cy_ff[COORD_W-1], cy_ff};
      lq        = ox_ext >>> WORD_SHIFT;
      rq        = (cx_ext + ROUND_UP) >>> WORD_SHIFT;
      rows_full = rq - lq;
      rows_in   = rows_full[ROWS_W-1:0];
      height_in = cy_ext - oy_ext;
      nwords_in = NWORDS_W'(rows_ff[ROWS_W-2:0]) * NWORDS_W'(height_ff[COORD_W-1:0]);
      space_left_in = (area_end_ff > next_free_ff) ? (area_end_ff - next_free_ff) : '0;
   end

   always_ff @(posedge clock) begin
      rows_ff       <= rows_in;
      height_ff     <= height_in;
      nwords_ff     <= nwords_in;
      space_left_ff <= space_left_in;
   end

   assign do_alloc = cmd.emit && (cmd.emit_sel == EM_ALLOC);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (cmd.emit && (cmd.emit_sel == EM_FREE) && fh_ok) begin
            valid_ff[fh_idx] <= 1'b0;
         end
         if (do_alloc) begin
            valid_ff[hidx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hidx_ff <= '0;
      end else if (cmd.hnext) begin
         hidx_ff <= hidx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_free_ff <= AREA_START_RST;
      end else if (cmd.comp_end) begin
         next_free_ff <= w_ff;
      end else if (do_alloc) begin
         next_free_ff <= next_free_ff + nwords_ff[ADDR_W-1:0];
      end
   end

   // Table reads come back registered, in the cycle after the address
   assign rd_base = ram_rdata[ENTRY_W-1:ADDR_W];
   assign rd_size = ram_rdata[ADDR_W-1:0];
   assign cand    = rd_v_ff && valid_ff[rd_idx_ff] && !done_ff[rd_idx_ff] &&
                    (rd_base >= w_ff) && (rd_base < low_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         done_ff <= '0;
      end else begin
         rd_v_ff <= cmd.scan_rd;
         if (cmd.comp_init) begin
            done_ff <= '0;
         end else if (cmd.pick_apply) begin
            done_ff[pick_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_idx_ff;
      if (cmd.comp_init) begin
         w_ff <= area_start_ff;
      end else if (cmd.pick_apply) begin
         w_ff <= w_ff + pick_size_ff;
      end
      if (cmd.scan_init) begin
         scan_idx_ff   <= '0;
         low_ff        <= next_free_ff;
         pick_found_ff <= 1'b0;
      end else begin
         if (cmd.scan_rd) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
         // keep the lowest base; the earlier handle wins a tie
         if (cand) begin
            low_ff        <= rd_base;
            pick_idx_ff   <= rd_idx_ff;
            pick_base_ff  <= rd_base;
            pick_size_ff  <= rd_size;
            pick_found_ff <= 1'b1;
         end
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = pick_idx_ff;
      ram_wdata = {w_ff, pick_size_ff};
      if (cmd.pick_apply) begin
         ram_we = 1'b1;
      end else if (do_alloc) begin
         ram_we    = 1'b1;
         ram_waddr = hidx_ff;
         ram_wdata = {next_free_ff, nwords_ff[ADDR_W-1:0]};
      end
   end

   cra_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_HANDLES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.scan_rd),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      rsp_valid_in  = cmd.emit;
      rsp_kind_in   = KIND_FINAL;
      rsp_status_in = ST_OK;
      rsp_handle_in = HANDLE_W'(hidx_ff);
      rsp_base_in   = '0;
      rsp_src_in    = '0;
      rsp_count_in  = '0;
      rsp_rows_in   = '0;
      case (cmd.emit_sel)
         EM_FREE: begin
            rsp_handle_in = fh_ff;
            rsp_status_in = fh_ok ? ST_OK : ST_BAD_HANDLE;
         end
         EM_NO_HANDLE: begin
            rsp_status_in = ST_NO_HANDLE;
            rsp_handle_in = '0;
         end
         EM_BAD_SIZE: begin
            rsp_status_in = ST_BAD_SIZE;
         end
         EM_NO_SPACE: begin
            rsp_status_in = ST_NO_SPACE;
         end
         EM_ALLOC: begin
            rsp_base_in  = next_free_ff;
            rsp_count_in = nwords_ff[ADDR_W-1:0];
            rsp_rows_in  = rows_ff;
         end
         EM_MOVE: begin
            rsp_kind_in   = KIND_MOVE;
            rsp_handle_in = HANDLE_W'(pick_idx_ff);
            rsp_base_in   = w_ff;
            rsp_src_in    = pick_base_ff;
            rsp_count_in  = pick_size_ff;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_src_ff    <= rsp_src_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_rows_ff   <= rsp_rows_in;
   end

   always_comb begin
      stat.hfree      = !valid_ff[hidx_ff];
      stat.hlast      = (hidx_ff == LAST_IDX);
      stat.bad_size   = rows_ff[ROWS_W-1] || (rows_ff == '0) ||
                        height_ff[HEIGHT_W-1] || (height_ff == '0);
      stat.fits       = (nwords_ff <= NWORDS_W'(space_left_ff));
      stat.scan_last  = (scan_idx_ff == LAST_IDX);
      stat.pick_found = pick_found_ff;
      stat.pick_moves = (pick_base_ff != w_ff);
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle     = rsp_handle_ff;
   assign rsp_base_addr  = rsp_base_ff;
   assign rsp_src_addr   = rsp_src_ff;
   assign rsp_word_count = rsp_count_ff;
   assign rsp_row_words  = rsp_rows_ff;
   assign rsp_last       = rsp_kind_ff;

endmodule

`default_nettype wire

>>> hw/rtl/compacting_region_allocator_top.sv
`default_nettype none

// Region allocator with a bump pointer and one-shot sliding compaction.
// Command channel: a transaction is taken when start is high and busy is low;
// req_cmd selects allocate (rectangle in req_origin_*/req_corner_*) or free
// (req_free_handle). busy stays high until the final result has been issued.
// Result channel: rsp_valid marks each result for exactly one cycle and it
// must be taken then. An allocation that needs compaction first issues one
// move result (rsp_kind 0) per region that slides down, for an external
// copier, then the final result with rsp_last set.
// Configuration: csr_index/csr_data write area_start (0) or area_end (1);
// csr_ready drops while busy, so writes are taken only while idle.
// Sequence: a free issues its result from S_FREE. An allocation inspects one
// handle per cycle in the free-handle search, then sizes the rectangle and
// checks the space. Compaction walks the whole handle table memory once per live
// region in the area, and once more to find that none is left.
// Reset clears every handle, restores the area registers and sets the bump
// pointer to area_start; no clearing pass is needed.
module compacting_region_allocator_top import cra_pkg::*; #(
   parameter int NUM_HANDLES = NUM_HANDLES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output      logic                      busy,
   input  wire logic                      req_cmd,
   input  wire logic signed [COORD_W-1:0] req_origin_x,
   input  wire logic signed [COORD_W-1:0] req_origin_y,
   input  wire logic signed [COORD_W-1:0] req_corner_x,
   input  wire logic signed [COORD_W-1:0] req_corner_y,
   input  wire logic [HANDLE_W-1:0]       req_free_handle,
   input  wire logic                      csr_valid,
   output      logic                      csr_ready,
   input  wire logic                      csr_index,
   input  wire logic [ADDR_W-1:0]         csr_data,
   output      logic                      rsp_valid,
   output      logic                      rsp_kind,
   output      logic [STATUS_W-1:0]       rsp_status,
   output      logic [HANDLE_W-1:0]       rsp_handle,
   output      logic [ADDR_W-1:0]         rsp_base_addr,
   output      logic [ADDR_W-1:0]         rsp_src_addr,
   output      logic [ADDR_W-1:0]         rsp_word_count,
   output      logic [ROW_W-1:0]          rsp_row_words,
   output      logic                      rsp_last
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = !busy;

   cra_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .busy    (busy),
      .stat    (stat),
      .cmd     (cmd)
   );

   cra_dp #(
      .NUM_HANDLES (NUM_HANDLES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_corner_x    (req_corner_x),
      .req_corner_y    (req_corner_y),
      .req_free_handle (req_free_handle),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_status      (rsp_status),
      .rsp_handle      (rsp_handle),
      .rsp_base_addr   (rsp_base_addr),
      .rsp_src_addr    (rsp_src_addr),
      .rsp_word_count  (rsp_word_count),
      .rsp_row_words   (rsp_row_words),
      .rsp_last        (rsp_last)
   );

`ifndef SYNTH
   // The final result ends the transaction in the same cycle
   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("final result issued while still busy");

   // Moves only occur in the middle of a compaction
   a_move_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy && (rsp_status == ST_OK) && (rsp_kind == KIND_MOVE))
      else $error("move result outside a compaction");

   // An accepted transaction always occupies the block for the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   // Failed commands carry no region
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && (rsp_status != ST_OK) |->
         (rsp_word_count == '0) && (rsp_base_addr == '0) && (rsp_row_words == '0))
      else $error("failed command reports a region");
`endif

endmodule

`default_nettype wire

>>> test/compacting_region_allocator_top_tb.sv
`default_nettype none

module compacting_region_allocator_top_tb;
   import cra_pkg::*;

   localparam int HANDLES        = NUM_HANDLES_DEF;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct {
      logic                      cmd;
      logic signed [COORD_W-1:0] ox;
      logic signed [COORD_W-1:0] oy;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic [HANDLE_W-1:0]       fh;
   } alloc_cmd_type;

   typedef struct packed {
      logic                kind;
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle;
      logic [ADDR_W-1:0]   base_addr;
      logic [ADDR_W-1:0]   src_addr;
      logic [ADDR_W-1:0]   word_count;
      logic [ROW_W-1:0]    row_words;
      logic                last;
   } region_result_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_cmd;
   logic signed [COORD_W-1:0] req_origin_x;
   logic signed [COORD_W-1:0] req_origin_y;
   logic signed [COORD_W-1:0] req_corner_x;
   logic signed [COORD_W-1:0] req_corner_y;
   logic [HANDLE_W-1:0]       req_free_handle;
   logic                      csr_valid;
   logic                      csr_ready;
   logic                      csr_index;
   logic [ADDR_W-1:0]         csr_data;
   logic                      rsp_valid;
   logic                      rsp_kind;
   logic [STATUS_W-1:0]       rsp_status;
   logic [HANDLE_W-1:0]       rsp_handle;
   logic [ADDR_W-1:0]         rsp_base_addr;
   logic [ADDR_W-1:0]         rsp_src_addr;
   logic [ADDR_W-1:0]         rsp_word_count;
   logic [ROW_W-1:0]          rsp_row_words;
   logic                      rsp_last;

   // Shadow of the handle table, bump pointer and area registers
   bit                tbl_valid [HANDLES];
   logic [ADDR_W-1:0] tbl_base  [HANDLES];
   logic [ADDR_W-1:0] tbl_size  [HANDLES];
   logic [ADDR_W-1:0] bump_ptr;
   logic [ADDR_W-1:0] cfg_start;
   logic [ADDR_W-1:0] cfg_end;
   logic [ADDR_W-1:0] area_base;

   region_result_type pending_results [$];

   int sender_idle_pct;
   int cmds_sent;
   int results_seen;
   int moves_seen;
   int regs_written;
   int failures;
   int quiet_cycles;

   compacting_region_allocator_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_corner_x    (req_corner_x),
      .req_corner_y    (req_corner_y),
      .req_free_handle (req_free_handle),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_status      (rsp_status),
      .rsp_handle      (rsp_handle),
      .rsp_base_addr   (rsp_base_addr),
      .rsp_src_addr    (rsp_src_addr),
      .rsp_word_count  (rsp_word_count),
      .rsp_row_words   (rsp_row_words),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void queue_result(logic kind, logic [STATUS_W-1:0] status,
                                        logic [HANDLE_W-1:0] handle,
                                        logic [ADDR_W-1:0] base_addr,
                                        logic [ADDR_W-1:0] src_addr,
                                        logic [ADDR_W-1:0] word_count,
                                        logic [ROW_W-1:0] row_words, logic last);
      region_result_type r;
      r = '{kind, status, handle, base_addr, src_addr, word_count, row_words, last};
      pending_results.push_back(r);
   endfunction

   // Slide live regions down from area_start in address order, one move per slide
   function automatic void slide_regions();
      bit                done [HANDLES];
      logic [ADDR_W-1:0] w;
      logic [ADDR_W-1:0] low;
      int                pick;
      for (int i = 0; i < HANDLES; i++) done[i] = 1'b0;
      w = cfg_start;
      for (int iter = 0; iter < HANDLES; iter++) begin
         pick = -1;
         low  = bump_ptr;
         for (int i = 0; i < HANDLES; i++) begin
            if (tbl_valid[i] && !done[i] && tbl_base[i] >= w && tbl_base[i] < low) begin
               low  = tbl_base[i];
               pick = i;
            end
         end
         if (pick < 0) break;
         done[pick] = 1'b1;
         if (tbl_base[pick] != w)
            queue_result(KIND_MOVE, ST_OK, HANDLE_W'(pick), w, tbl_base[pick],
                         tbl_size[pick], '0, 1'b0);
         tbl_base[pick] = w;
         w = w + tbl_size[pick];
      end
      bump_ptr = w;
   endfunction

   function automatic longint words_left();
      return (cfg_end > bump_ptr) ? longint'(cfg_end - bump_ptr) : 64'sd0;
   endfunction

   function automatic void predict_command(alloc_cmd_type c);
      int     h;
      int     lq;
      int     rq;
      int     rows;
      int     height;
      longint nwords;
      if (c.cmd == CMD_FREE) begin
         if (c.fh >= HANDLES) begin
            queue_result(KIND_FINAL, ST_BAD_HANDLE, c.fh, '0, '0, '0, '0, 1'b1);
         end else begin
            tbl_valid[c.fh] = 1'b0;
            queue_result(KIND_FINAL, ST_OK, c.fh, '0, '0, '0, '0, 1'b1);
         end
         return;
      end
      h = HANDLES;
      for (int i = HANDLES - 1; i >= 0; i--) if (!tbl_valid[i]) h = i;
      if (h == HANDLES) begin
         queue_result(KIND_FINAL, ST_NO_HANDLE, '0, '0, '0, '0, '0, 1'b1);
         return;
      end
      // Left edge rounds down, right edge rounds up to a whole word
      lq     = int'(c.ox) >>> WORD_SHIFT;
      rq     = (int'(c.cx) + WORD_BITS - 1) >>> WORD_SHIFT;
      rows   = rq - lq;
      height = int'(c.cy) - int'(c.oy);
      if (rows <= 0 || height <= 0) begin
         queue_result(KIND_FINAL, ST_BAD_SIZE, HANDLE_W'(h), '0, '0, '0, '0, 1'b1);
         return;
      end
      nwords = longint'(rows) * longint'(height);
      if (nwords > words_left()) begin
         slide_regions();
         if (nwords > words_left()) begin
            queue_result(KIND_FINAL, ST_NO_SPACE, HANDLE_W'(h), '0, '0, '0, '0, 1'b1);
            return;
         end
      end
      tbl_valid[h] = 1'b1;
      tbl_base[h]  = bump_ptr;
      tbl_size[h]  = ADDR_W'(nwords);
      bump_ptr     = bump_ptr + ADDR_W'(nwords);
      queue_result(KIND_FINAL, ST_OK, HANDLE_W'(h), tbl_base[h], '0, ADDR_W'(nwords),
                   ROW_W'(rows), 1'b1);
   endfunction

   function automatic alloc_cmd_type make_alloc(int ox, int oy, int cx, int cy);
      alloc_cmd_type c;
      c.cmd = CMD_ALLOC;
      c.ox  = COORD_W'(ox);
      c.oy  = COORD_W'(oy);
      c.cx  = COORD_W'(cx);
      c.cy  = COORD_W'(cy);
      c.fh  = HANDLE_W'($urandom);
      return c;
   endfunction

   function automatic alloc_cmd_type make_free(int h);
      alloc_cmd_type c;
      c.cmd = CMD_FREE;
      c.ox  = COORD_W'($urandom);
      c.oy  = COORD_W'($urandom);
      c.cx  = COORD_W'($urandom);
      c.cy  = COORD_W'($urandom);
      c.fh  = HANDLE_W'(h);
      return c;
   endfunction

   function automatic alloc_cmd_type small_alloc();
      int ox;
      int oy;
      ox = int'($urandom_range(0, 60767)) - 32768;
      oy = int'($urandom_range(0, 65471)) - 32768;
      return make_alloc(ox, oy, ox + int'($urandom_range(1, 1024)),
                        oy + int'($urandom_range(1, 48)));
   endfunction

   function automatic alloc_cmd_type random_command();
      int            pick;
      int            ox;
      int            oy;
      alloc_cmd_type c;
      pick = $urandom_range(99);
      if (pick < 55) begin
         c = small_alloc();
      end else if (pick < 85) begin
         c = make_free(($urandom_range(9) != 0) ? $urandom_range(0, HANDLES - 1)
                                                : $urandom_range(HANDLES, 63));
      end else if (pick < 90) begin
         ox = int'($urandom_range(0, 49151)) - 32768;
         oy = int'($urandom_range(0, 65279)) - 32768;
         c = make_alloc(ox, oy, ox + int'($urandom_range(1, 16384)),
                        oy + int'($urandom_range(1, 256)));
      end else begin
         // noise: every field drawn over its full range
         c = make_free($urandom_range(0, 63));
         c.cmd = 1'($urandom);
      end
      return c;
   endfunction

   task automatic issue_cmd(alloc_cmd_type c);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start           <= 1'b1;
      req_cmd         <= c.cmd;
      req_origin_x    <= c.ox;
      req_origin_y    <= c.oy;
      req_corner_x    <= c.cx;
      req_corner_y    <= c.cy;
      req_free_handle <= c.fh;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_command(c);
      cmds_sent++;
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_area(logic idx, logic [ADDR_W-1:0] value);
      wait_quiet();
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_AREA_START) cfg_start = value;
      else cfg_end = value;
      regs_written++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_basic_alloc();
      issue_cmd(make_alloc(0, 0, 32, 1));
      issue_cmd(make_alloc(-33, -5, 33, 5));
      issue_cmd(make_alloc(5, 0, 40, 2));
      issue_cmd(make_alloc(-32768, 100, -32736, 101));
      issue_cmd(make_alloc(32736, -32768, 32767, -32767));
   endtask

   task automatic test_bad_size();
      issue_cmd(make_alloc(64, 0, 64, 10));
      issue_cmd(make_alloc(0, 5, 32, 5));
      issue_cmd(make_alloc(100, 0, 40, 3));
      issue_cmd(make_alloc(0, 10, 32, 2));
      issue_cmd(make_alloc(32767, 32767, -32768, -32768));
   endtask

   task automatic test_free_cases();
      issue_cmd(make_free(0));
      issue_cmd(make_free(7));
      issue_cmd(make_free(HANDLES));
      issue_cmd(make_free(63));
   endtask

   task automatic test_compaction();
      // largest rectangle: slides the regions above the hole, still no space
      issue_cmd(make_alloc(-32768, -32768, 32767, 32767));
      // everything already in place now
      issue_cmd(make_alloc(-32768, -32768, 32767, 32767));
      issue_cmd(make_alloc(0, 0, 4096, 50));
      issue_cmd(make_alloc(0, 0, 4096, 50));
      issue_cmd(make_free(0));
      issue_cmd(make_alloc(0, 0, 4096, 50));
      // area end at zero leaves no space at all
      write_area(REG_AREA_END, '0);
      issue_cmd(make_alloc(0, 0, 32, 1));
      write_area(REG_AREA_END, AREA_END_RST);
   endtask

   task automatic test_table_full();
      write_area(REG_AREA_START, '0);
      write_area(REG_AREA_END, '1);
      repeat (HANDLES + 2) issue_cmd(small_alloc());
      for (int i = 0; i < HANDLES; i++) issue_cmd(make_free(i));
   endtask

   task automatic test_random_traffic(int idle_pct, logic [ADDR_W-1:0] a_start,
                                      logic [ADDR_W-1:0] a_end, int n);
      sender_idle_pct = idle_pct;
      write_area(REG_AREA_START, a_start);
      write_area(REG_AREA_END, a_end);
      // pull the bump pointer back into the new area
      issue_cmd(make_alloc(-32768, -32768, 32767, 32767));
      repeat (n) issue_cmd(random_command());
   endtask

   task automatic show_result(string tag, region_result_type r);
      $display("  %s kind %0d status %0d handle %0d base %h src %h count %0d rows %0d last %0d",
               tag, r.kind, r.status, r.handle, r.base_addr, r.src_addr, r.word_count,
               r.row_words, r.last);
   endtask

   always @(posedge clock) begin
      region_result_type got;
      region_result_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_kind, rsp_status, rsp_handle, rsp_base_addr, rsp_src_addr,
                rsp_word_count, rsp_row_words, rsp_last};
         results_seen++;
         if (got.kind == KIND_MOVE) moves_seen++;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("result %0d arrived with nothing outstanding", results_seen);
               show_result("got ", got);
            end
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               failures++;
               if (failures <= 10) begin
                  $display("result %0d differs", results_seen);
                  show_result("want", want);
                  show_result("got ", got);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("compacting_region_allocator_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_cmd         = CMD_ALLOC;
      req_origin_x    = '0;
      req_origin_y    = '0;
      req_corner_x    = '0;
      req_corner_y    = '0;
      req_free_handle = '0;
      csr_valid       = 1'b0;
      csr_index       = REG_AREA_START;
      csr_data        = '0;
      quiet_cycles    = 0;
      cmds_sent       = 0;
      results_seen    = 0;
      moves_seen      = 0;
      regs_written    = 0;
      failures        = 0;
      sender_idle_pct = 20;
      for (int i = 0; i < HANDLES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_base[i]  = '0;
         tbl_size[i]  = '0;
      end
      cfg_start = AREA_START_RST;
      cfg_end   = AREA_END_RST;
      bump_ptr  = AREA_START_RST;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_alloc();
      test_bad_size();
      test_free_cases();
      test_compaction();
      test_table_full();
      // place the area end a random distance above a random area start
      area_base = ADDR_W'($urandom_range(0, 20'h7FFFF));
      test_random_traffic(20, area_base,
                          ADDR_W'(area_base + $urandom_range(4000, 30000)), 80);
      test_random_traffic(57, 20'hFC000, '1, 80);
      test_random_traffic(0, AREA_START_RST, AREA_END_RST, 80);

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d commands across directed, full-table and three area settings",
               cmds_sent);
      $display("%0d results (%0d slides), %0d register writes, %0d failures",
               results_seen, moves_seen, regs_written, failures);
      if (failures == 0 && pending_results.size() == 0)
         $display("compacting_region_allocator_top: match");
      else
         $display("compacting_region_allocator_top: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
